>>> design/software_travel_limit_check_defines.svh
// Assertion macros used by the travel limit check top-level design file
`ifndef SOFTWARE_TRAVEL_LIMIT_CHECK_DEFINES_SVH
`define SOFTWARE_TRAVEL_LIMIT_CHECK_DEFINES_SVH

// Same-cycle implication, checked out of reset
`define STLC_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("travel limit check assertion failed");

// Next-cycle implication, checked out of reset
`define STLC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("travel limit check assertion failed");

`endif

>>> design/stlc_pkg.sv
// Types and constants for the software travel limit check
`timescale 1ns / 1ps

package stlc_pkg;

  // Windows provided in hardware and windows actually in use
  localparam int WIN_MAX = 3;
  localparam int WIN_CNT = 3;

  localparam int POS_W   = 48;
  localparam int UPP_W   = 32;
  localparam int PULSE_W = 32;
  localparam int FRAC_W  = 16;
  localparam int CFG_IDX_W = 3;

  // Bit of limit_enables that holds the G22 mode
  localparam int G22_BIT = 3;
  // Bit of the invalid mask that flags an empty intersection
  localparam int EMPTY_BIT = 3;

  typedef logic signed [POS_W-1:0] pos_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LIMIT_ENABLES = 3'd0,
    REG_WIN1_NEG      = 3'd1,
    REG_WIN1_POS      = 3'd2,
    REG_WIN2_NEG      = 3'd3,
    REG_WIN2_POS      = 3'd4,
    REG_WIN3_NEG      = 3'd5,
    REG_WIN3_POS      = 3'd6,
    REG_UNITS_PER_PULSE = 3'd7
  } cfg_reg_t;

  // Evaluated configuration, handed from the register block to the datapath
  typedef struct packed {
    logic [WIN_MAX-1:0] en;    // window enabled
    logic [WIN_MAX-1:0] ok;    // window enabled and well formed
    logic [3:0]         mask;  // invalid windows and empty intersection
  } cfg_eval_t;

endpackage

>>> design/stlc_cfg_regs.sv
// Configuration registers and window validity evaluation
`timescale 1ns / 1ps

module stlc_cfg_regs import stlc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [POS_W-1:0]     cfg_wr_data,
  output pos_t                 win_neg [WIN_MAX],
  output pos_t                 win_pos [WIN_MAX],
  output logic [UPP_W-1:0]     units_per_pulse,
  output cfg_eval_t            eval
);

  logic [3:0]       enables_r;
  pos_t             win_neg_r [WIN_MAX];
  pos_t             win_pos_r [WIN_MAX];
  logic [UPP_W-1:0] upp_r;
  cfg_eval_t        eval_r;
  cfg_eval_t        eval_nxt;

  // Take register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enables_r <= '0;
      upp_r     <= '0;
      for (int g = 0; g < WIN_MAX; g++) begin
        win_neg_r[g] <= '0;
        win_pos_r[g] <= '0;
      end
    end else if (cfg_wr_en) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_LIMIT_ENABLES:   enables_r    <= cfg_wr_data[3:0];
        REG_WIN1_NEG:        win_neg_r[0] <= cfg_wr_data;
        REG_WIN1_POS:        win_pos_r[0] <= cfg_wr_data;
        REG_WIN2_NEG:        win_neg_r[1] <= cfg_wr_data;
        REG_WIN2_POS:        win_pos_r[1] <= cfg_wr_data;
        REG_WIN3_NEG:        win_neg_r[2] <= cfg_wr_data;
        REG_WIN3_POS:        win_pos_r[2] <= cfg_wr_data;
        REG_UNITS_PER_PULSE: upp_r        <= cfg_wr_data[UPP_W-1:0];
        default: ;
      endcase
    end
  end

  // Evaluate windows: enable, ordering, and pairwise overlap
  always_comb begin
    eval_nxt = '0;
    for (int g = 0; g < WIN_MAX; g++) begin
      eval_nxt.en[g] = (g < WIN_CNT) && enables_r[g] && ((g != 0) || enables_r[G22_BIT]);
      eval_nxt.ok[g] = eval_nxt.en[g] && (win_neg_r[g] < win_pos_r[g]);
      eval_nxt.mask[g] = eval_nxt.en[g] && !(win_neg_r[g] < win_pos_r[g]);
    end
    // Intersection is empty when some well-formed window starts past another's end
    for (int i = 0; i < WIN_MAX; i++) begin
      for (int j = 0; j < WIN_MAX; j++) begin
        if ((i != j) && eval_nxt.ok[i] && eval_nxt.ok[j] && (win_neg_r[i] > win_pos_r[j])) begin
          eval_nxt.mask[EMPTY_BIT] = 1'b1;
        end
      end
    end
  end

  // Hold the evaluation in a register behind the configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eval_r <= '0;
    end else begin
      eval_r <= eval_nxt;
    end
  end

  assign win_neg         = win_neg_r;
  assign win_pos         = win_pos_r;
  assign units_per_pulse = upp_r;
  assign eval            = eval_r;

endmodule

>>> design/software_travel_limit_check.sv
// Pipeline: input transfer, stage-1 register (converted position), result register.
// Throughput: one item per cycle unless out_stall holds the result; the 32x33 pulse-to-position
// multiply sits between the input and the stage-1 register, the window compares before the result.
// A scan updates the stored limit-hit flags as its result is loaded, so later
// pre-checks report them in order.
// Reset (synchronous, rst_n low) clears all configuration registers, the flags and both valids.
`timescale 1ns / 1ps
`include "software_travel_limit_check_defines.svh"

module software_travel_limit_check import stlc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  // configuration writes
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [POS_W-1:0]     cfg_wr_data,
  // input channel
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 in_cmd,
  input  logic                 in_axis_exists,
  input  logic                 in_axis_homed,
  input  logic signed [PULSE_W-1:0] in_actual_pulses,
  input  logic signed [POS_W-1:0]   in_target_position,
  // result channel
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [WIN_MAX-1:0]   out_positive_hit,
  output logic [WIN_MAX-1:0]   out_negative_hit,
  output logic [3:0]           out_invalid_mask,
  output logic                 out_target_allowed,
  output logic                 out_jog_positive_allowed,
  output logic                 out_jog_negative_allowed
);

  pos_t             win_neg [WIN_MAX];
  pos_t             win_pos [WIN_MAX];
  logic [UPP_W-1:0] units_per_pulse;
  cfg_eval_t        eval;

  stlc_cfg_regs u_cfg (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_wr_data     (cfg_wr_data),
    .win_neg         (win_neg),
    .win_pos         (win_pos),
    .units_per_pulse (units_per_pulse),
    .eval            (eval)
  );

  // Pipeline control
  logic s1_valid_r;
  logic out_valid_r;
  logic out_ready;
  logic s1_ready;
  logic in_xfer;
  logic s1_adv;

  assign out_ready = !out_valid_r || !out_stall;
  assign s1_ready  = !s1_valid_r || out_ready;
  assign in_stall  = !s1_ready;
  assign in_xfer   = in_valid && s1_ready;
  assign s1_adv    = s1_valid_r && out_ready;

  // Stage 1: convert pulses to position (floor of product / 2^16), or take the target for a command
  logic signed [PULSE_W+UPP_W:0] prod;
  logic                          s1_cmd_r;
  logic                          s1_active_r;
  pos_t                          s1_coord_r;

  assign prod = $signed(in_actual_pulses) * $signed({1'b0, units_per_pulse});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_cmd_r    <= in_cmd;
      s1_active_r <= in_axis_exists && in_axis_homed;
      s1_coord_r  <= in_cmd ? in_target_position : prod[FRAC_W+POS_W-1:FRAC_W];
    end
  end

  // Stage 2: window compares, flag rebuild and permissions
  logic [3:0]         mask;
  logic [WIN_MAX-1:0] pos_flags_r;
  logic [WIN_MAX-1:0] neg_flags_r;
  logic [WIN_MAX-1:0] pos_flags_nxt;
  logic [WIN_MAX-1:0] neg_flags_nxt;
  logic [WIN_MAX-1:0] outside;
  logic               allowed_nxt;
  logic [3:0]         mask_r;
  logic               allowed_r;
  logic               jog_pos_r;
  logic               jog_neg_r;

  assign mask = s1_active_r ? eval.mask : 4'd0;

  always_comb begin
    pos_flags_nxt = pos_flags_r;
    neg_flags_nxt = neg_flags_r;
    outside       = '0;
    for (int g = 0; g < WIN_MAX; g++) begin
      outside[g] = eval.ok[g] && ((s1_coord_r < win_neg[g]) || (s1_coord_r > win_pos[g]));
    end
    if (!s1_cmd_r) begin
      // Scan: rebuild flags from scratch
      for (int g = 0; g < WIN_MAX; g++) begin
        pos_flags_nxt[g] = s1_active_r &&
                           (mask[g] || (mask[EMPTY_BIT] && eval.en[g]) ||
                            (eval.ok[g] && (s1_coord_r >= win_pos[g])));
        neg_flags_nxt[g] = s1_active_r &&
                           (mask[g] || (mask[EMPTY_BIT] && eval.en[g]) ||
                            (eval.ok[g] && (s1_coord_r <= win_neg[g])));
      end
      allowed_nxt = 1'b1;
    end else begin
      allowed_nxt = !s1_active_r || ((mask == 4'd0) && (outside == '0));
    end
  end

  // Load the result register and commit the flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      pos_flags_r <= '0;
      neg_flags_r <= '0;
    end else begin
      if (out_ready) begin
        out_valid_r <= s1_valid_r;
      end
      if (s1_adv) begin
        pos_flags_r <= pos_flags_nxt;
        neg_flags_r <= neg_flags_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      mask_r    <= mask;
      allowed_r <= allowed_nxt;
      jog_pos_r <= (mask == 4'd0) && (pos_flags_nxt == '0);
      jog_neg_r <= (mask == 4'd0) && (neg_flags_nxt == '0);
    end
  end

  assign out_valid                = out_valid_r;
  assign out_positive_hit         = pos_flags_r;
  assign out_negative_hit         = neg_flags_r;
  assign out_invalid_mask         = mask_r;
  assign out_target_allowed       = allowed_r;
  assign out_jog_positive_allowed = jog_pos_r;
  assign out_jog_negative_allowed = jog_neg_r;

  // A pre-check leaves the stored flags untouched
  `STLC_ASSERT_NEXT(a_precheck_keeps_flags, s1_adv && s1_cmd_r, $stable({pos_flags_r, neg_flags_r}))
  // A held stage-1 item stays until the result side frees up
  `STLC_ASSERT_NEXT(a_s1_holds, s1_valid_r && !out_ready, s1_valid_r)
  // Any invalid configuration blocks both jog directions
  `STLC_ASSERT_SAME(a_mask_blocks_jog, out_valid_r && (mask_r != 4'd0), !jog_pos_r && !jog_neg_r)
  // An empty intersection needs at least two well-formed windows
  `STLC_ASSERT_SAME(a_empty_needs_two, eval.mask[EMPTY_BIT], $countones(eval.ok) >= 2)

endmodule
